[rtl/tbstat_pkg.sv]
// ----------------------------------------------------------------------------
// tbstat_pkg
// Shared types and constants for the tile block statistics core.
// ----------------------------------------------------------------------------
package tbstat_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [24:0] TOTAL_MAX = 25'h1FFFFFF;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_GRID_WIDTH       = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT      = 3'd1;
  localparam logic [2:0] REG_CHUNK_WIDTH      = 3'd2;
  localparam logic [2:0] REG_CHUNK_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_HEIGHT_ENABLE    = 3'd4;
  localparam logic [2:0] REG_COLLISION_ENABLE = 3'd5;

  typedef struct packed {
    logic [12:0] grid_width;
    logic [12:0] grid_height;
    logic [8:0]  chunk_width;
    logic [8:0]  chunk_height;
    logic        height_enable;
    logic        collision_enable;
  } tbstat_cfg_t;

  typedef struct packed {
    logic signed [15:0] height_level;
    logic               blocked;
  } tbstat_cell_t;

  typedef struct packed {
    logic [11:0]        chunk_col;
    logic [11:0]        chunk_row;
    logic [16:0]        blocked_count;
    logic signed [15:0] level_min;
    logic signed [15:0] level_max;
    logic               levels_found;
    logic [24:0]        total_blocked;
    logic               last_chunk;
  } tbstat_res_t;

  // Per-cell control from the raster scanner
  typedef struct packed {
    logic        start;   // first cell of a chunk: accumulator restarts
    logic        emit;    // last cell of a chunk: result goes out
    logic        last;    // last cell of the map
    logic [11:0] col;
    logic [11:0] row;
  } tbstat_ctl_t;

  // One accumulator word per chunk column
  typedef struct packed {
    logic               seen;
    logic [16:0]        count;
    logic signed [15:0] level_min;
    logic signed [15:0] level_max;
  } tbstat_entry_t;

endpackage

[rtl/tbstat_cfg.sv]
// ----------------------------------------------------------------------------
// tbstat_cfg
// APB register file: map and chunk sizes, feature enables.
// ----------------------------------------------------------------------------
module tbstat_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbstat_pkg::ADDR_W-1:0]   paddr,
  input  logic [tbstat_pkg::DATA_W-1:0]   pwdata,
  output logic [tbstat_pkg::DATA_W-1:0]   prdata,
  output logic                            pready,
  output tbstat_pkg::tbstat_cfg_t         cfg
);
  import tbstat_pkg::*;

  logic [2:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width       <= 13'd1;
      cfg.grid_height      <= 13'd1;
      cfg.chunk_width      <= 9'd16;
      cfg.chunk_height     <= 9'd16;
      cfg.height_enable    <= 1'b0;
      cfg.collision_enable <= 1'b0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:       cfg.grid_width       <= pwdata[12:0];
        REG_GRID_HEIGHT:      cfg.grid_height      <= pwdata[12:0];
        REG_CHUNK_WIDTH:      cfg.chunk_width      <= pwdata[8:0];
        REG_CHUNK_HEIGHT:     cfg.chunk_height     <= pwdata[8:0];
        REG_HEIGHT_ENABLE:    cfg.height_enable    <= pwdata[0];
        REG_COLLISION_ENABLE: cfg.collision_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_GRID_WIDTH:       prdata = DATA_W'(cfg.grid_width);
      REG_GRID_HEIGHT:      prdata = DATA_W'(cfg.grid_height);
      REG_CHUNK_WIDTH:      prdata = DATA_W'(cfg.chunk_width);
      REG_CHUNK_HEIGHT:     prdata = DATA_W'(cfg.chunk_height);
      REG_HEIGHT_ENABLE:    prdata = DATA_W'(cfg.height_enable);
      REG_COLLISION_ENABLE: prdata = DATA_W'(cfg.collision_enable);
      default:              prdata = '0;
    endcase
  end

endmodule

[rtl/tbstat_scan.sv]
// ----------------------------------------------------------------------------
// tbstat_scan
// Raster position tracker: cell, in-chunk offset and chunk index counters.
// ----------------------------------------------------------------------------
module tbstat_scan #(
  parameter int MAX_MAP_WIDTH  = 4096,
  parameter int MAX_CHUNK_SIZE = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbstat_pkg::tbstat_cfg_t  cfg,
  input  logic                     advance,
  output logic [((MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1)-1:0] idx,
  output tbstat_pkg::tbstat_ctl_t  ctl
);
  import tbstat_pkg::*;

  localparam int XW = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
  localparam int OW = (MAX_CHUNK_SIZE > 1) ? $clog2(MAX_CHUNK_SIZE) : 1;

  // zero reads as one, oversize saturates at the limit
  function automatic logic [12:0] clamp_size(logic [12:0] v, int unsigned hi);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) r = 13'd1;
    else if (32'(v) > hi) r = 13'(hi);
    return r;
  endfunction

  logic [XW-1:0] cell_x, cell_y, col_index, row_index;
  logic [OW-1:0] offset_x, offset_y;
  logic [12:0]   mw, mh, cw, ch;
  logic          row_end, map_end_y, off_x_end, off_y_end;

  assign mw = clamp_size(cfg.grid_width, MAX_MAP_WIDTH);
  assign mh = clamp_size(cfg.grid_height, MAX_MAP_WIDTH);
  assign cw = clamp_size(13'(cfg.chunk_width), MAX_CHUNK_SIZE);
  assign ch = clamp_size(13'(cfg.chunk_height), MAX_CHUNK_SIZE);

  // "at or beyond" tests pull counters back after mid-map size changes
  assign row_end   = (32'(cell_x) + 32'd1) >= 32'(mw);
  assign map_end_y = (32'(cell_y) + 32'd1) >= 32'(mh);
  assign off_x_end = (32'(offset_x) + 32'd1) >= 32'(cw);
  assign off_y_end = (32'(offset_y) + 32'd1) >= 32'(ch);

  assign idx       = col_index;
  assign ctl.start = (offset_x == '0) && (offset_y == '0);
  assign ctl.emit  = (off_x_end || row_end) && (off_y_end || map_end_y);
  assign ctl.last  = row_end && map_end_y;
  assign ctl.col   = 12'(col_index);
  assign ctl.row   = 12'(row_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_x    <= '0;
      cell_y    <= '0;
      offset_x  <= '0;
      offset_y  <= '0;
      col_index <= '0;
      row_index <= '0;
    end else if (advance) begin
      if (row_end) begin
        cell_x    <= '0;
        offset_x  <= '0;
        col_index <= '0;
        if (map_end_y) begin
          cell_y    <= '0;
          offset_y  <= '0;
          row_index <= '0;
        end else begin
          cell_y <= cell_y + XW'(1);
          if (off_y_end) begin
            offset_y  <= '0;
            row_index <= row_index + XW'(1);
          end else begin
            offset_y <= offset_y + OW'(1);
          end
        end
      end else begin
        cell_x <= cell_x + XW'(1);
        if (off_x_end) begin
          offset_x  <= '0;
          col_index <= col_index + XW'(1);
        end else begin
          offset_x <= offset_x + OW'(1);
        end
      end
    end
  end

endmodule

[rtl/tbstat_acc.sv]
// ----------------------------------------------------------------------------
// tbstat_acc
// Per-column accumulator memory with read-modify-write, write forwarding,
// post-reset clearing sweep and running blocked total.
// ----------------------------------------------------------------------------
module tbstat_acc #(
  parameter int MAX_MAP_WIDTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbstat_pkg::tbstat_cfg_t  cfg,
  input  logic                     cell_take,   // transaction accepted
  input  tbstat_pkg::tbstat_cell_t cell_data,
  input  logic [((MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1)-1:0] idx,
  input  tbstat_pkg::tbstat_ctl_t  ctl,
  input  logic                     res_free,    // output register can load
  output logic                     ready,
  output logic                     res_load,
  output tbstat_pkg::tbstat_res_t  res
);
  import tbstat_pkg::*;

  localparam int XW = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;

  tbstat_entry_t mem [MAX_MAP_WIDTH];
  tbstat_entry_t rdata;

  // stage 1: item whose entry is being read back
  logic          s1_v;
  logic [XW-1:0] s1_idx;
  tbstat_ctl_t   s1_ctl;
  tbstat_cell_t  s1_cell;
  logic          s1_go;

  // last write, forwarded over the same-edge read
  logic          lw_v;
  logic [XW-1:0] lw_idx;
  tbstat_entry_t lw_data;

  logic          clr;
  logic [XW-1:0] clr_addr;

  tbstat_entry_t old_e, new_e;
  logic [25:0]   sum;
  logic [24:0]   total, grand_total;

  assign s1_go = s1_v && (!s1_ctl.emit || res_free);
  assign ready = !clr && (!s1_v || s1_go);

  always_comb begin
    if (s1_ctl.start)                      old_e = '0;
    else if (lw_v && (lw_idx == s1_idx))   old_e = lw_data;
    else                                   old_e = rdata;

    new_e = old_e;
    if (cfg.collision_enable && s1_cell.blocked && (old_e.count != COUNT_MAX))
      new_e.count = old_e.count + 17'd1;
    if (cfg.height_enable) begin
      new_e.seen = 1'b1;
      if (!old_e.seen) begin
        new_e.level_min = s1_cell.height_level;
        new_e.level_max = s1_cell.height_level;
      end else begin
        if ($signed(s1_cell.height_level) < $signed(old_e.level_min))
          new_e.level_min = s1_cell.height_level;
        if ($signed(s1_cell.height_level) > $signed(old_e.level_max))
          new_e.level_max = s1_cell.height_level;
      end
    end
  end

  assign sum   = {1'b0, grand_total} + 26'(new_e.count);
  assign total = sum[25] ? TOTAL_MAX : sum[24:0];

  assign res_load          = s1_go && s1_ctl.emit;
  assign res.chunk_col     = s1_ctl.col;
  assign res.chunk_row     = s1_ctl.row;
  assign res.blocked_count = new_e.count;
  assign res.level_min     = new_e.seen ? new_e.level_min : 16'sd0;
  assign res.level_max     = new_e.seen ? new_e.level_max : 16'sd0;
  assign res.levels_found  = new_e.seen;
  assign res.total_blocked = total;
  assign res.last_chunk    = s1_ctl.last;

  // memory port: read at accept, write on retire or clearing sweep
  always_ff @(posedge clk) begin
    if (cell_take) rdata <= mem[idx];
    if (clr)        mem[clr_addr] <= '0;
    else if (s1_go) mem[s1_idx]   <= new_e;
  end

  always_ff @(posedge clk) begin
    if (cell_take) begin
      s1_idx  <= idx;
      s1_ctl  <= ctl;
      s1_cell <= cell_data;
    end
    if (s1_go) begin
      lw_idx  <= s1_idx;
      lw_data <= new_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v        <= 1'b0;
      lw_v        <= 1'b0;
      clr         <= 1'b1;
      clr_addr    <= '0;
      grand_total <= '0;
    end else begin
      if (cell_take)  s1_v <= 1'b1;
      else if (s1_go) s1_v <= 1'b0;
      if (s1_go) lw_v <= 1'b1;
      if (clr) begin
        clr_addr <= clr_addr + XW'(1);
        if (clr_addr == XW'(MAX_MAP_WIDTH - 1)) clr <= 1'b0;
      end
      if (res_load) grand_total <= s1_ctl.last ? 25'd0 : total;
    end
  end

endmodule

[rtl/tile_block_statistics_core.sv]
// ----------------------------------------------------------------------------
// tile_block_statistics_core
// Per-chunk blocked count and height range over a raster-ordered map.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload        | handshake
//   ---------+-----------+----------------+-------------------------------
//   cell     | in        | tbstat_cell_t  | cell_valid / cell_stall
//   chunk    | out       | tbstat_res_t   | chunk_valid / chunk_stall
//   apb      | in/out    | 32-bit regs    | psel / penable / pready
//
// One cell per cycle sustained while cell_stall is low. A cell reads its
// column's accumulator at the accept edge, is merged and written back
// when stage 1 retires (the previous write is forwarded when both hit the
// same column), and a chunk result lands in the output register at that
// same edge.
// After rst a clearing sweep zeroes the accumulator memory, one entry
// per cycle; cell_stall is high meanwhile.
// A stalled result holds; cells keep flowing until another result is due.
//
module tile_block_statistics_core #(
  parameter int MAX_MAP_WIDTH  = 4096,
  parameter int MAX_CHUNK_SIZE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbstat_pkg::ADDR_W-1:0]  paddr,
  input  logic [tbstat_pkg::DATA_W-1:0]  pwdata,
  output logic [tbstat_pkg::DATA_W-1:0]  prdata,
  output logic                           pready,
  input  logic                           cell_valid,
  output logic                           cell_stall,
  input  tbstat_pkg::tbstat_cell_t       cell_data,
  output logic                           chunk_valid,
  input  logic                           chunk_stall,
  output tbstat_pkg::tbstat_res_t        chunk
);
  import tbstat_pkg::*;

  localparam int XW = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;

  tbstat_cfg_t   cfg;
  tbstat_ctl_t   ctl;
  tbstat_res_t   res;
  logic [XW-1:0] idx;
  logic          ready, take, res_load, res_free;

  assign cell_stall = !ready;
  assign take       = cell_valid && ready;
  // output register frees when empty or being drained this edge
  assign res_free   = !chunk_valid || !chunk_stall;

  tbstat_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbstat_scan #(
    .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
    .MAX_CHUNK_SIZE (MAX_CHUNK_SIZE)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (take),
    .idx     (idx),
    .ctl     (ctl)
  );

  tbstat_acc #(
    .MAX_MAP_WIDTH (MAX_MAP_WIDTH)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cell_take (take),
    .cell_data (cell_data),
    .idx       (idx),
    .ctl       (ctl),
    .res_free  (res_free),
    .ready     (ready),
    .res_load  (res_load),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= 1'b0;
    end else if (res_load) begin
      chunk_valid <= 1'b1;
    end else if (!chunk_stall) begin
      chunk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) chunk <= res;
  end

endmodule

[bench/chunk_stats_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunk_stats_checker
// Watches the register bus and both streams of the tile block statistics
// core, predicts every chunk result and compares it field by field.
// ----------------------------------------------------------------------------
module chunk_stats_checker #(
  parameter int MAX_MAP_WIDTH  = 4096,
  parameter int MAX_CHUNK_SIZE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [tbstat_pkg::ADDR_W-1:0]  paddr,
  input  logic [tbstat_pkg::DATA_W-1:0]  pwdata,
  input  logic                           cell_valid,
  input  logic                           cell_stall,
  input  tbstat_pkg::tbstat_cell_t       cell_data,
  input  logic                           chunk_valid,
  input  logic                           chunk_stall,
  input  tbstat_pkg::tbstat_res_t        chunk_data,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);
  import tbstat_pkg::*;

  tbstat_cfg_t regs;

  // per chunk column accumulators
  logic [16:0]        col_count [MAX_MAP_WIDTH];
  logic signed [15:0] col_low   [MAX_MAP_WIDTH];
  logic signed [15:0] col_high  [MAX_MAP_WIDTH];
  logic               col_seen  [MAX_MAP_WIDTH];

  logic [11:0] pos_x, pos_y, col_no, row_no;
  logic [7:0]  off_x, off_y;
  logic [24:0] blocked_sum;

  tbstat_res_t pending_chunks [$];
  tbstat_res_t want;
  int unsigned fails = 0;

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic predict_chunk(input tbstat_cell_t c);
    int unsigned mw, mh, cw, ch, sum;
    logic [11:0] slot;
    logic signed [15:0] lvl;
    bit row_end, map_end, end_x, end_y;
    tbstat_res_t r;
    mw = fit_size(32'(regs.grid_width), MAX_MAP_WIDTH);
    mh = fit_size(32'(regs.grid_height), MAX_MAP_WIDTH);
    cw = fit_size(32'(regs.chunk_width), MAX_CHUNK_SIZE);
    ch = fit_size(32'(regs.chunk_height), MAX_CHUNK_SIZE);
    lvl = c.height_level;
    slot = col_no;
    // boundaries are "at or beyond" so a mid-map size change recovers
    row_end = (pos_x + 32'd1) >= mw;
    map_end = (pos_y + 32'd1) >= mh;
    end_x = ((off_x + 32'd1) >= cw) || row_end;
    end_y = ((off_y + 32'd1) >= ch) || map_end;

    if (off_x == '0 && off_y == '0) begin
      col_count[slot] = '0;
      col_seen[slot] = 1'b0;
      col_low[slot] = '0;
      col_high[slot] = '0;
    end
    if (regs.collision_enable && c.blocked && col_count[slot] != COUNT_MAX)
      col_count[slot] = col_count[slot] + 17'd1;
    if (regs.height_enable) begin
      if (!col_seen[slot]) begin
        col_low[slot] = lvl;
        col_high[slot] = lvl;
        col_seen[slot] = 1'b1;
      end else begin
        if (lvl < col_low[slot]) col_low[slot] = lvl;
        if (lvl > col_high[slot]) col_high[slot] = lvl;
      end
    end

    if (end_x && end_y) begin
      sum = blocked_sum + col_count[slot];
      blocked_sum = (sum > TOTAL_MAX) ? TOTAL_MAX : 25'(sum);
      r.chunk_col = col_no;
      r.chunk_row = row_no;
      r.blocked_count = col_count[slot];
      r.level_min = col_seen[slot] ? col_low[slot] : '0;
      r.level_max = col_seen[slot] ? col_high[slot] : '0;
      r.levels_found = col_seen[slot];
      r.total_blocked = blocked_sum;
      r.last_chunk = row_end && map_end;
      pending_chunks = {pending_chunks, r};
    end

    if (row_end) begin
      pos_x = '0;
      off_x = '0;
      col_no = '0;
      if (map_end) begin
        pos_y = '0;
        off_y = '0;
        row_no = '0;
        blocked_sum = '0;
      end else begin
        pos_y = pos_y + 12'd1;
        if ((off_y + 32'd1) >= ch) begin
          off_y = '0;
          row_no = row_no + 12'd1;
        end else begin
          off_y = off_y + 8'd1;
        end
      end
    end else begin
      pos_x = pos_x + 12'd1;
      if ((off_x + 32'd1) >= cw) begin
        off_x = '0;
        col_no = col_no + 12'd1;
      end else begin
        off_x = off_x + 8'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.grid_width = 13'd1;
      regs.grid_height = 13'd1;
      regs.chunk_width = 9'd16;
      regs.chunk_height = 9'd16;
      regs.height_enable = 1'b0;
      regs.collision_enable = 1'b0;
      for (int i = 0; i < MAX_MAP_WIDTH; i++) begin
        col_count[i] = '0;
        col_low[i] = '0;
        col_high[i] = '0;
        col_seen[i] = 1'b0;
      end
      {pos_x, pos_y, col_no, row_no, off_x, off_y, blocked_sum} = '0;
      pending_chunks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[tbstat_pkg::ADDR_W-1:2])
          REG_GRID_WIDTH:       regs.grid_width = pwdata[12:0];
          REG_GRID_HEIGHT:      regs.grid_height = pwdata[12:0];
          REG_CHUNK_WIDTH:      regs.chunk_width = pwdata[8:0];
          REG_CHUNK_HEIGHT:     regs.chunk_height = pwdata[8:0];
          REG_HEIGHT_ENABLE:    regs.height_enable = pwdata[0];
          REG_COLLISION_ENABLE: regs.collision_enable = pwdata[0];
          default: ;
        endcase
      end
      if (cell_valid && !cell_stall) predict_chunk(cell_data);
      if (chunk_valid && !chunk_stall) begin
        if (pending_chunks.size() == 0) begin
          $error("chunk result with none expected: col %0d row %0d",
                 chunk_data.chunk_col, chunk_data.chunk_row);
          fails++;
        end else begin
          want = pending_chunks.pop_front();
          check_field("chunk_col", want.chunk_col, chunk_data.chunk_col);
          check_field("chunk_row", want.chunk_row, chunk_data.chunk_row);
          check_field("blocked_count", want.blocked_count, chunk_data.blocked_count);
          check_field("level_min", want.level_min, chunk_data.level_min);
          check_field("level_max", want.level_max, chunk_data.level_max);
          check_field("levels_found", want.levels_found, chunk_data.levels_found);
          check_field("total_blocked", want.total_blocked, chunk_data.total_blocked);
          check_field("last_chunk", want.last_chunk, chunk_data.last_chunk);
        end
      end
    end
    mismatches <= fails;
    outstanding <= pending_chunks.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for tile_block_statistics_core. Register writes go
// over the APB port, map cells stream in with random gaps, chunk results
// drain under random stall; chunk_stats_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import tbstat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;  // clearing sweep + slowest run, many times
  localparam int unsigned LONG_HOLD   = 80;      // cycles of the one long output hold-off
  localparam int unsigned SETTLE      = 4;       // settling margin after the core's last result

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  cell_valid;
  logic                  cell_stall;
  tbstat_cell_t          cell_data;
  logic                  chunk_valid;
  logic                  chunk_stall;
  tbstat_res_t           chunk_data;

  int unsigned mismatches;
  int unsigned outstanding;   // chunk results predicted but not yet seen
  int unsigned sent_cells = 0;
  int unsigned cycle_count = 0;
  bit          long_hold = 1'b0;    // raised by the stimulus, served once by the receiver
  bit          hold_served = 1'b0;

  // Ports in declaration order.
  tile_block_statistics_core dut (
    clk, rst, psel, penable, pwrite, paddr, pwdata, prdata, pready,
    cell_valid, cell_stall, cell_data, chunk_valid, chunk_stall, chunk_data
  );

  chunk_stats_checker watch (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
    .chunk_valid(chunk_valid), .chunk_stall(chunk_stall), .chunk_data(chunk_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Register bus: setup cycle, then access cycle until pready. psel stays
  // high across back-to-back writes; set_config drops it at the end.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(input int unsigned mw, input int unsigned mh,
                            input int unsigned cw, input int unsigned ch,
                            input bit he, input bit ce);
    write_reg(REG_GRID_WIDTH, mw);
    write_reg(REG_GRID_HEIGHT, mh);
    write_reg(REG_CHUNK_WIDTH, cw);
    write_reg(REG_CHUNK_HEIGHT, ch);
    write_reg(REG_HEIGHT_ENABLE, 32'(he));
    write_reg(REG_COLLISION_ENABLE, 32'(ce));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Cell stream. A random gap (mostly none, a few long) precedes each
  // transaction unless the caller wants back-to-back pressure; the payload
  // holds until the core takes it.
  // ---------------------------------------------------------------------------
  task automatic send_cell(input tbstat_cell_t c, input bit eager);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (!eager) begin
      if (pick >= 95)      gap = $urandom_range(15, 40);
      else if (pick >= 85) gap = $urandom_range(3, 8);
      else if (pick >= 60) gap = $urandom_range(1, 2);
    end
    if (gap != 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_data <= c;
    do @(posedge clk); while (cell_stall);
    sent_cells++;
  endtask

  // Wait for every predicted chunk, then for the pipeline to settle: the
  // last cells of a phase may not close a chunk and still be in flight.
  task automatic drain();
    cell_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic tbstat_cell_t cell_of(input int lvl, input bit blk);
    tbstat_cell_t c;
    c.height_level = 16'(lvl);
    c.blocked = blk;
    return c;
  endfunction

  // Height mix: extremes, a narrow band around zero (ties and sign
  // changes), otherwise anything.
  function automatic tbstat_cell_t random_cell();
    tbstat_cell_t c;
    case ($urandom_range(0, 9))
      0:       c.height_level = 16'sh8000;
      1:       c.height_level = 16'sh7FFF;
      2, 3:    c.height_level = 16'(int'($urandom_range(0, 6)) - 3);
      default: c.height_level = 16'($urandom);
    endcase
    c.blocked = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, most short, a few long, plus quiet
  // stretches. Once the stimulus raises long_hold, the stall is held for the
  // LONG_HOLD hold-off so the core backs up into its cell input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned stall_for;
    int unsigned free_for;
    chunk_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold && !hold_served) begin
        chunk_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      stall_for = 0;
        else if (pick < 80) stall_for = $urandom_range(1, 3);
        else if (pick < 95) stall_for = $urandom_range(4, 10);
        else                stall_for = $urandom_range(20, 60);
        free_for = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        if (stall_for != 0) begin
          chunk_stall <= 1'b1;
          repeat (stall_for) @(posedge clk);
        end
        chunk_stall <= 1'b0;
        repeat (free_for) begin
          @(posedge clk);
          if (long_hold && !hold_served) break;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mw, mh, cw, ch, ncells, phase;
    bit he, ce;
    int lvl_set [12];
    bit blk_set [12];

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cell_valid <= 1'b0;
    cell_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 1x1 map, 16x16 chunks, both grids off. Every cell is
    // a whole map; results carry zero counts and no heights. The core's
    // clearing sweep holds these off until it is done.
    send_cell(cell_of(-32768, 1), 1'b0);
    send_cell(cell_of(32767, 1), 1'b0);
    drain();

    // Two 3x2 maps in 2x2 chunks, right column clipped; height extremes,
    // ties and sign changes. The second map checks the total restarts.
    set_config(3, 2, 2, 2, 1, 1);
    lvl_set = '{-32768, 32767, 0, -1, 1, -32768, 32767, 32767, -2, 100, -100, 0};
    blk_set = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 0, 0, 1};
    for (int i = 0; i < 12; i++) send_cell(cell_of(lvl_set[i], blk_set[i]), 1'b0);
    drain();

    // Zero sizes read as 1, oversize values saturate (map 4096 tall,
    // chunks 256 tall). No chunk closes; the map is left unfinished.
    set_config(0, 8191, 0, 511, 1, 1);
    repeat (5) send_cell(random_cell(), 1'b0);
    drain();

    // Sizes changed mid-map: the row counters are already past the new
    // chunk height, and column 0 keeps its half-built accumulator.
    set_config(3, 1, 5, 5, 0, 1);
    repeat (3) send_cell(random_cell(), 1'b0);
    drain();

    // Random phases, a few fixed ones first: back-pressure with one result
    // per cell, the map size extremes with tiny chunks, full-size chunks
    // clipped by a small map.
    phase = 0;
    while (sent_cells < 550) begin
      case (phase)
        0: begin
          {mw, mh, cw, ch, he, ce} = {32'd10, 32'd6, 32'd1, 32'd1, 1'b1, 1'b1};
          ncells = 60;
        end
        1: begin
          {mw, mh, cw, ch, he, ce} = {32'd4096, 32'd4096, 32'd1, 32'd1, 1'b1, 1'b1};
          ncells = 30;
        end
        2: begin
          {mw, mh, cw, ch, he, ce} = {32'd1, 32'd4096, 32'd256, 32'd1, 1'b0, 1'b1};
          ncells = 30;
        end
        3: begin
          {mw, mh, cw, ch, he, ce} = {32'd7, 32'd5, 32'd256, 32'd256, 1'b1, 1'b1};
          ncells = 42;
        end
        default: begin
          mw = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
          mh = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
          cw = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 256);
          ch = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 256);
          he = ($urandom_range(0, 4) != 0);
          ce = ($urandom_range(0, 4) != 0);
          // mostly whole maps; sometimes stop partway so the next
          // settings land mid-map
          if (mw * mh <= 100 && $urandom_range(0, 5) != 0)
            ncells = mw * mh * $urandom_range(1, 2);
          else
            ncells = $urandom_range(1, 60);
        end
      endcase
      // keep the run close to the planned item count
      if (ncells > 560 - sent_cells) ncells = 560 - sent_cells;
      if (phase == 0) long_hold = 1'b1;
      set_config(mw, mh, cw, ch, he, ce);
      repeat (ncells) send_cell(random_cell(), phase == 0);
      drain();
      phase++;
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
